// ===== rtl/swm_pkg.sv =====
// Shared types and constants for the sliding window median filter.
package swm_pkg;

	// Width and reset value of the window length register.
	localparam int unsigned CFG_WIDTH = 5;
	localparam logic [CFG_WIDTH-1:0] CFG_RESET = 5'd5;

	// Action codes carried with each input request.
	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// Control broadcast from the top level to every cell.
	typedef struct packed {
		logic push;       // insert the new sample this cycle
		logic clear;      // drop the whole history
		logic remove_en;  // window is full, so the oldest entry leaves
	} ctl_t;

	// Flags that one cell shows to its neighbors.
	typedef struct packed {
		logic valid;  // cell holds a sample
		logic ngt;    // stored sample is not greater than the new sample
		logic rb;     // the leaving entry sits in this cell or below it
	} flags_t;

endpackage

// ===== rtl/sliding_window_median.sv =====
// Sliding window median filter: sorted chain of cells with a registered result.
//
// Input channel: in_valid, in_stall, action, sample. A request is taken at a
// rising edge with in_valid high and in_stall low. A push request inserts the
// sample and yields one result; a clear request empties the history and
// yields nothing.
// Output channel: out_valid, out_stall, filtered, window_full. A result is
// taken at a rising edge with out_valid high and out_stall low.
// The result is registered and shows in the cycle after its request. One
// request is taken per cycle while in_stall is low; the cell chain sorts the
// new sample in and drops the oldest entry in the same cycle. The median tap
// is read from the chain's next state once full, the raw sample before.
// While a result waits under out_stall, in_stall is raised, so at most one
// result is held and none is lost. The user must write window_size through
// window_size_we only while the block is idle; the block does not enforce
// this. A write also empties the history. Zero acts as one, values above
// MAX_WINDOW act as MAX_WINDOW. Reset empties the history, drops any pending
// result and sets the window length to five.
module sliding_window_median #(
	parameter int unsigned MAX_WINDOW   = 16,
	parameter int unsigned SAMPLE_WIDTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                window_size_we,
	input  logic [swm_pkg::CFG_WIDTH-1:0]       window_size,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic signed [SAMPLE_WIDTH-1:0]      sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]      filtered,
	output logic                                window_full
);

	localparam int unsigned IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int unsigned FW = $clog2(MAX_WINDOW + 1);

	logic [swm_pkg::CFG_WIDTH-1:0]  win_q;
	logic [FW-1:0]                  fill_q;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] filtered_q;
	logic                           window_full_q;

	logic [FW-1:0]                  eff;
	logic [IW-1:0]                  age_last;
	logic [IW-1:0]                  mid;
	logic                           accept;
	logic                           full_now;
	logic                           full_after;
	swm_pkg::ctl_t                  ctl;

	swm_pkg::flags_t                flags   [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] vals    [MAX_WINDOW];
	logic [IW-1:0]                  ages    [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] nxt_val [MAX_WINDOW];

	always_comb begin
		if (win_q == '0) begin
			eff = FW'(1);
		end else if (int'(win_q) > int'(MAX_WINDOW)) begin
			eff = FW'(MAX_WINDOW);
		end else begin
			eff = FW'(win_q);
		end
	end

	assign age_last   = IW'(eff - FW'(1));
	assign mid        = IW'((eff - FW'(1)) >> 1);
	assign full_now   = (fill_q == eff);
	assign full_after = full_now || ((fill_q + FW'(1)) == eff);

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;

	assign ctl.push      = accept && (action == swm_pkg::ACT_PUSH);
	assign ctl.clear     = window_size_we || (accept && (action == swm_pkg::ACT_CLEAR));
	assign ctl.remove_en = full_now;

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		swm_pkg::flags_t                lf;
		swm_pkg::flags_t                rf;
		logic signed [SAMPLE_WIDTH-1:0] lv;
		logic signed [SAMPLE_WIDTH-1:0] rv;
		logic [IW-1:0]                  la;
		logic [IW-1:0]                  ra;

		// The front of the chain sees an edge that sorts below everything,
		// the back sees an empty cell.
		if (i == 0) begin : g_first
			assign lf = '{valid: 1'b1, ngt: 1'b1, rb: 1'b0};
			assign lv = '0;
			assign la = '0;
		end else begin : g_mid_l
			assign lf = flags[i-1];
			assign lv = vals[i-1];
			assign la = ages[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_last
			assign rf = '{valid: 1'b0, ngt: 1'b0, rb: 1'b0};
			assign rv = '0;
			assign ra = '0;
		end else begin : g_mid_r
			assign rf = flags[i+1];
			assign rv = vals[i+1];
			assign ra = ages[i+1];
		end

		swm_cell #(
			.SAMPLE_WIDTH (SAMPLE_WIDTH),
			.AGE_WIDTH    (IW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.new_sample  (sample),
			.age_last    (age_last),
			.left_flags  (lf),
			.left_val    (lv),
			.left_age    (la),
			.right_flags (rf),
			.right_val   (rv),
			.right_age   (ra),
			.flags       (flags[i]),
			.val         (vals[i]),
			.age         (ages[i]),
			.nxt_val     (nxt_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q       <= swm_pkg::CFG_RESET;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (window_size_we) begin
				win_q <= window_size;
			end
			if (ctl.clear) begin
				fill_q <= '0;
			end else if (ctl.push && !full_now) begin
				fill_q <= fill_q + FW'(1);
			end
			if (ctl.push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			filtered_q    <= full_after ? nxt_val[mid] : sample;
			window_full_q <= full_after;
		end
	end

	assign out_valid   = out_valid_q;
	assign filtered    = filtered_q;
	assign window_full = window_full_q;

endmodule

// ===== rtl/swm_cell.sv =====
// One cell of the sorted chain: holds a sample and its age, shifts with its neighbors.
module swm_cell #(
	parameter int unsigned SAMPLE_WIDTH = 32,
	parameter int unsigned AGE_WIDTH    = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  swm_pkg::ctl_t                  ctl,
	input  logic signed [SAMPLE_WIDTH-1:0] new_sample,
	input  logic [AGE_WIDTH-1:0]           age_last,
	input  swm_pkg::flags_t                left_flags,
	input  logic signed [SAMPLE_WIDTH-1:0] left_val,
	input  logic [AGE_WIDTH-1:0]           left_age,
	input  swm_pkg::flags_t                right_flags,
	input  logic signed [SAMPLE_WIDTH-1:0] right_val,
	input  logic [AGE_WIDTH-1:0]           right_age,
	output swm_pkg::flags_t                flags,
	output logic signed [SAMPLE_WIDTH-1:0] val,
	output logic [AGE_WIDTH-1:0]           age,
	output logic signed [SAMPLE_WIDTH-1:0] nxt_val
);

	logic                           valid_q;
	logic signed [SAMPLE_WIDTH-1:0] val_q;
	logic [AGE_WIDTH-1:0]           age_q;

	logic                           rm;
	logic                           ngt;
	logic                           rb;
	// The list with the leaving entry taken out, seen at this index and the one below.
	logic signed [SAMPLE_WIDTH-1:0] r_val;
	logic [AGE_WIDTH-1:0]           r_age;
	logic                           r_valid;
	logic                           r_ngt;
	logic signed [SAMPLE_WIDTH-1:0] rl_val;
	logic [AGE_WIDTH-1:0]           rl_age;
	logic                           rl_valid;
	logic                           rl_ngt;
	logic [AGE_WIDTH-1:0]           nxt_age;
	logic                           nxt_valid;

	assign rm  = ctl.remove_en && valid_q && (age_q == age_last);
	assign ngt = valid_q && !(new_sample < val_q);
	assign rb  = left_flags.rb || rm;

	assign flags.valid = valid_q;
	assign flags.ngt   = ngt;
	assign flags.rb    = rb;
	assign val         = val_q;
	assign age         = age_q;

	always_comb begin
		r_val    = rb ? right_val         : val_q;
		r_age    = rb ? right_age         : age_q;
		r_valid  = rb ? right_flags.valid : valid_q;
		r_ngt    = rb ? right_flags.ngt   : ngt;
		rl_val   = left_flags.rb ? val_q   : left_val;
		rl_age   = left_flags.rb ? age_q   : left_age;
		rl_valid = left_flags.rb ? valid_q : left_flags.valid;
		rl_ngt   = left_flags.rb ? ngt     : left_flags.ngt;

		// Entries not above the new sample stay in front of it, the new one comes
		// right after them, and everything behind moves up by one place.
		if (r_ngt) begin
			nxt_val   = r_val;
			nxt_age   = r_age + AGE_WIDTH'(1);
			nxt_valid = r_valid;
		end else if (rl_ngt) begin
			nxt_val   = new_sample;
			nxt_age   = '0;
			nxt_valid = 1'b1;
		end else begin
			nxt_val   = rl_val;
			nxt_age   = rl_age + AGE_WIDTH'(1);
			nxt_valid = rl_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end else if (ctl.push) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

endmodule
